FILE: hw/rtl/rqi_pkg.sv
// rqi_pkg: shared types, fixed-point formats and constants for the ray/quad
// intersection pipeline. No dependencies; imported by every rqi module.

package rqi_pkg;

	// Number formats
	localparam int CW        = 32;            // coordinate width, Q(CW-F).F
	localparam int FRAC_BITS = 16;            // coordinate fraction bits
	localparam int LANE_W    = 21;            // packed vector lane width
	localparam int VEC_W     = 3 * LANE_W;
	localparam int EDGE_FRAC = 10;            // corner / edge lanes
	localparam int UNIT_FRAC = 19;            // normal / scale lanes
	localparam int UV_FRAC   = 20;            // alpha / beta output
	localparam int UV_W      = UV_FRAC + 1;
	localparam int UV_SHIFT  = FRAC_BITS + EDGE_FRAC + UNIT_FRAC - UV_FRAC;
	localparam int CORNER_SHL = FRAC_BITS - EDGE_FRAC;

	// Configuration port
	localparam int CFG_W     = VEC_W;
	localparam int REG_IDX_W = 3;
	localparam int MAT_W     = 8;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_CORNER   = 3'd0,
		REG_EDGE_U   = 3'd1,
		REG_EDGE_V   = 3'd2,
		REG_NORMAL   = 3'd3,
		REG_OFFSET   = 3'd4,
		REG_SCALE    = 3'd5,
		REG_MATERIAL = 3'd6
	} reg_idx_t;

	// Plane solve widths
	localparam int PN_W  = LANE_W + CW;       // normal * coordinate
	localparam int DEN_W = PN_W + 2;          // three-term dot
	localparam int NUM_W = DEN_W + 1;         // offset minus dot

	// Divider widths
	localparam int X_W  = NUM_W + FRAC_BITS;  // scaled dividend
	localparam int R_W  = DEN_W + 1;          // partial remainder
	localparam int OV_W = DEN_W + CW;         // overflow compare

	// Surface widths
	localparam int TP_W   = 2 * CW;               // t * dir
	localparam int PW_W   = TP_W - FRAC_BITS + 1; // unclamped point lane
	localparam int DIFF_W = CW + 1;               // point minus corner
	localparam int CP_W   = DIFF_W + LANE_W;      // cross product term
	localparam int CR_W   = CP_W + 1;             // cross product lane
	localparam int SPLIT  = 28;                   // low slice of a cross lane
	localparam int PL_W   = LANE_W + SPLIT + 1;
	localparam int PH_W   = LANE_W + CR_W - SPLIT;
	localparam int LS_W   = PL_W + 2;
	localparam int HS_W   = PH_W + 2;
	localparam int ACC_W  = 80;

	// Exclusive upper bound of a scaled dot that maps into [0, 1.0]
	localparam logic [ACC_W-1:0] UV_BOUND =
		((ACC_W'(1) << UV_FRAC) + ACC_W'(1)) << UV_SHIFT;

	typedef struct packed {
		logic [2:0][CW-1:0] org;
		logic [2:0][CW-1:0] dir;
		logic [CW-1:0]      t_min;
		logic [CW-1:0]      t_max;
	} ray_t;

	typedef struct packed {
		logic miss;
		logic front;
		logic neg;
	} flags_t;

	function automatic logic signed [LANE_W-1:0] lane(input logic [VEC_W-1:0] vec,
		input int unsigned idx);
		return vec[idx*LANE_W +: LANE_W];
	endfunction

endpackage

FILE: hw/rtl/rqi_plane.sv
// rqi_plane: plane dot products and magnitudes for the t division (3 stages).
// Depends on rqi_pkg.

module rqi_plane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  rqi_pkg::ray_t                 ray,
	input  logic [rqi_pkg::VEC_W-1:0]     normal,
	input  logic signed [rqi_pkg::CW-1:0] offset,
	output logic                          out_valid,
	output rqi_pkg::ray_t                 out_ray,
	output rqi_pkg::flags_t               out_flags,
	output logic [rqi_pkg::NUM_W-1:0]     num_mag,
	output logic [rqi_pkg::DEN_W-1:0]     den_mag
);
	import rqi_pkg::*;

	logic                    v_s1, v_s2, v_s3;
	ray_t                    ray_s1, ray_s2, ray_s3;
	logic signed [PN_W-1:0]  pn_s1 [3];
	logic signed [PN_W-1:0]  po_s1 [3];
	logic signed [DEN_W-1:0] den_s2;
	logic signed [NUM_W-1:0] num_s2;
	logic [NUM_W-1:0]        nmag_s3;
	logic [DEN_W-1:0]        dmag_s3;
	flags_t                  flags_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1: normal . dir and normal . origin terms
			for (int i = 0; i < 3; i++) begin
				pn_s1[i] <= lane(normal, i) * $signed(ray.dir[i]);
				po_s1[i] <= lane(normal, i) * $signed(ray.org[i]);
			end
			ray_s1 <= ray;
			// stage 2: denominator and numerator, both Q(F+19)
			den_s2 <= DEN_W'(pn_s1[0]) + DEN_W'(pn_s1[1]) + DEN_W'(pn_s1[2]);
			num_s2 <= (NUM_W'(offset) <<< UNIT_FRAC) - NUM_W'(po_s1[0])
				- NUM_W'(po_s1[1]) - NUM_W'(po_s1[2]);
			ray_s2 <= ray_s1;
			// stage 3: sign-magnitude split
			nmag_s3 <= num_s2[NUM_W-1] ? NUM_W'(-num_s2) : NUM_W'(num_s2);
			dmag_s3 <= den_s2[DEN_W-1] ? DEN_W'(-den_s2) : DEN_W'(den_s2);
			flags_s3.neg   <= num_s2[NUM_W-1] ^ den_s2[DEN_W-1];
			flags_s3.front <= den_s2[DEN_W-1];
			flags_s3.miss  <= (den_s2 == '0);
			ray_s3 <= ray_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_ray   = ray_s3;
	assign out_flags = flags_s3;
	assign num_mag   = nmag_s3;
	assign den_mag   = dmag_s3;

endmodule

FILE: hw/rtl/rqi_div.sv
// rqi_div: pipelined restoring divider for t, one quotient bit per stage,
// with an up-front range check. Depends on rqi_pkg.

module rqi_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  rqi_pkg::ray_t             ray,
	input  rqi_pkg::flags_t           flags,
	input  logic [rqi_pkg::NUM_W-1:0] num_mag,
	input  logic [rqi_pkg::DEN_W-1:0] den_mag,
	output logic                      out_valid,
	output rqi_pkg::ray_t             out_ray,
	output rqi_pkg::flags_t           out_flags,
	output logic [rqi_pkg::CW-1:0]    quot
);
	import rqi_pkg::*;

	logic             v_s   [CW+1];
	ray_t             ray_s [CW+1];
	flags_t           flg_s [CW+1];
	logic [R_W-1:0]   rem_s [CW+1];
	logic [CW-1:0]    xl_s  [CW+1];
	logic [CW-1:0]    q_s   [CW+1];
	logic [DEN_W-1:0] den_s [CW+1];

	logic [X_W-1:0]  dividend;
	logic [OV_W-1:0] lim;
	logic            ovf;
	logic [R_W:0]    sh_c [CW];
	logic            ge_c [CW];

	// quotient would exceed the signed range: |num|*2^F >= (2^(CW-1)+neg)*|den|
	always_comb begin
		dividend = {num_mag, {FRAC_BITS{1'b0}}};
		lim      = (OV_W'(den_mag) << (CW - 1)) + (flags.neg ? OV_W'(den_mag) : '0);
		ovf      = OV_W'(dividend) >= lim;
	end

	always_comb begin
		for (int k = 0; k < CW; k++) begin
			sh_c[k] = {rem_s[k], xl_s[k][CW-1]};
			ge_c[k] = sh_c[k] >= (R_W+1)'(den_s[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= CW; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k <= CW; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= R_W'(dividend[X_W-1:CW]);
			xl_s[0]  <= dividend[CW-1:0];
			q_s[0]   <= '0;
			den_s[0] <= den_mag;
			ray_s[0] <= ray;
			flg_s[0] <= '{miss: flags.miss | ovf, front: flags.front, neg: flags.neg};
			for (int k = 1; k <= CW; k++) begin
				rem_s[k] <= ge_c[k-1] ? R_W'(sh_c[k-1] - (R_W+1)'(den_s[k-1]))
					: R_W'(sh_c[k-1]);
				q_s[k]   <= {q_s[k-1][CW-2:0], ge_c[k-1]};
				xl_s[k]  <= xl_s[k-1] << 1;
				den_s[k] <= den_s[k-1];
				ray_s[k] <= ray_s[k-1];
				flg_s[k] <= flg_s[k-1];
			end
		end
	end

	assign out_valid = v_s[CW];
	assign out_ray   = ray_s[CW];
	assign out_flags = flg_s[CW];
	assign quot      = q_s[CW];

endmodule

FILE: hw/rtl/rqi_surface.sv
// rqi_surface: hit point, interval and range checks, cross products and the
// scaled dots for alpha and beta (9 stages). Depends on rqi_pkg.

module rqi_surface (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  rqi_pkg::ray_t                 ray,
	input  rqi_pkg::flags_t               flags,
	input  logic [rqi_pkg::CW-1:0]        quot,
	input  logic [rqi_pkg::VEC_W-1:0]     corner,
	input  logic [rqi_pkg::VEC_W-1:0]     edge_u,
	input  logic [rqi_pkg::VEC_W-1:0]     edge_v,
	input  logic [rqi_pkg::VEC_W-1:0]     scale,
	output logic                          out_valid,
	output logic                          miss,
	output logic                          front,
	output logic [rqi_pkg::CW-1:0]        t_val,
	output logic [2:0][rqi_pkg::CW-1:0]   point,
	output logic signed [rqi_pkg::ACC_W-1:0] acc_a,
	output logic signed [rqi_pkg::ACC_W-1:0] acc_b
);
	import rqi_pkg::*;

	localparam int NST = 9;

	logic        v_s   [1:NST];
	logic        miss_s[1:NST];
	logic        frt_s [1:NST];
	logic [CW-1:0] t_s [1:NST];

	ray_t                     ray_s1;
	logic [2:0][CW-1:0]       org_s2;
	logic signed [TP_W-1:0]   tp_s2  [3];
	logic signed [PW_W-1:0]   pw_s3  [3];
	logic [2:0][CW-1:0]       p_s4, p_s5, p_s6, p_s7, p_s8, p_s9;
	logic signed [DIFF_W-1:0] diff_s4[3];
	logic signed [CP_W-1:0]   ap_s5[3], an_s5[3], bp_s5[3], bn_s5[3];
	logic signed [CR_W-1:0]   ca_s6[3], cb_s6[3];
	logic signed [PL_W-1:0]   pla_s7[3], plb_s7[3];
	logic signed [PH_W-1:0]   pha_s7[3], phb_s7[3];
	logic signed [LS_W-1:0]   la_s8, lb_s8;
	logic signed [HS_W-1:0]   ha_s8, hb_s8;
	logic signed [ACC_W-1:0]  acca_s9, accb_s9;

	logic signed [CW-1:0] t_c;
	logic                 in_rng;
	logic                 fits [3];

	always_comb begin
		t_c    = $signed(t_s[1]);
		in_rng = (t_c >= $signed(ray_s1.t_min)) && (t_c <= $signed(ray_s1.t_max));
		for (int i = 0; i < 3; i++)
			fits[i] = (&pw_s3[i][PW_W-1:CW-1]) | ~(|pw_s3[i][PW_W-1:CW-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NST; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[1] <= in_valid;
			for (int k = 2; k <= NST; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s1: signed t from quotient magnitude
			t_s[1]    <= flags.neg ? CW'(-$signed(quot)) : quot;
			miss_s[1] <= flags.miss;
			frt_s[1]  <= flags.front;
			ray_s1    <= ray;
			// s2: t * dir, closed interval test
			for (int i = 0; i < 3; i++) tp_s2[i] <= t_c * $signed(ray_s1.dir[i]);
			org_s2    <= ray_s1.org;
			miss_s[2] <= miss_s[1] | ~in_rng;
			// s3: point lanes before range check, floor shift
			for (int i = 0; i < 3; i++)
				pw_s3[i] <= PW_W'($signed(org_s2[i])) + PW_W'(tp_s2[i] >>> FRAC_BITS);
			miss_s[3] <= miss_s[2];
			// s4: overflow check, offset from corner aligned to QF
			for (int i = 0; i < 3; i++) begin
				p_s4[i]    <= pw_s3[i][CW-1:0];
				diff_s4[i] <= DIFF_W'($signed(pw_s3[i][CW-1:0]))
					- (DIFF_W'(lane(corner, i)) <<< CORNER_SHL);
			end
			miss_s[4] <= miss_s[3] | ~fits[0] | ~fits[1] | ~fits[2];
			// s6: cross product lanes
			for (int i = 0; i < 3; i++) begin
				ca_s6[i] <= CR_W'(ap_s5[i]) - CR_W'(an_s5[i]);
				cb_s6[i] <= CR_W'(bp_s5[i]) - CR_W'(bn_s5[i]);
			end
			// s7: scale . cross, split into low and high partial products
			for (int i = 0; i < 3; i++) begin
				pla_s7[i] <= lane(scale, i) * $signed({1'b0, ca_s6[i][SPLIT-1:0]});
				pha_s7[i] <= lane(scale, i) * $signed(ca_s6[i][CR_W-1:SPLIT]);
				plb_s7[i] <= lane(scale, i) * $signed({1'b0, cb_s6[i][SPLIT-1:0]});
				phb_s7[i] <= lane(scale, i) * $signed(cb_s6[i][CR_W-1:SPLIT]);
			end
			// s8: lane sums per slice
			la_s8 <= LS_W'(pla_s7[0]) + LS_W'(pla_s7[1]) + LS_W'(pla_s7[2]);
			ha_s8 <= HS_W'(pha_s7[0]) + HS_W'(pha_s7[1]) + HS_W'(pha_s7[2]);
			lb_s8 <= LS_W'(plb_s7[0]) + LS_W'(plb_s7[1]) + LS_W'(plb_s7[2]);
			hb_s8 <= HS_W'(phb_s7[0]) + HS_W'(phb_s7[1]) + HS_W'(phb_s7[2]);
			// s9: recombine slices
			acca_s9 <= (ACC_W'(ha_s8) <<< SPLIT) + ACC_W'(la_s8);
			accb_s9 <= (ACC_W'(hb_s8) <<< SPLIT) + ACC_W'(lb_s8);

			p_s5 <= p_s4; p_s6 <= p_s5; p_s7 <= p_s6; p_s8 <= p_s7; p_s9 <= p_s8;
			for (int k = 2; k <= NST; k++) begin
				t_s[k]   <= t_s[k-1];
				frt_s[k] <= frt_s[k-1];
			end
			for (int k = 5; k <= NST; k++) miss_s[k] <= miss_s[k-1];
		end
	end

	// s5: the twelve cross product terms
	for (genvar i = 0; i < 3; i++) begin : g_cross
		localparam int J = (i + 1) % 3;
		localparam int K = (i + 2) % 3;
		always_ff @(posedge clk) begin
			if (en) begin
				ap_s5[i] <= diff_s4[J] * lane(edge_v, K);
				an_s5[i] <= diff_s4[K] * lane(edge_v, J);
				bp_s5[i] <= lane(edge_u, J) * diff_s4[K];
				bn_s5[i] <= lane(edge_u, K) * diff_s4[J];
			end
		end
	end

	assign out_valid = v_s[NST];
	assign miss      = miss_s[NST];
	assign front     = frt_s[NST];
	assign t_val     = t_s[NST];
	assign point     = p_s9;
	assign acc_a     = acca_s9;
	assign acc_b     = accb_s9;

endmodule

FILE: hw/rtl/ray_quad_intersect_unit.sv
// ray_quad_intersect_unit: one ray against one configured parallelogram.
// Throughput: one transaction per cycle unless a result is stalled; the divider
// gives one quotient bit per stage (32 stages) and sets most of the depth.
// Whole pipeline advances together; it holds while a result is stalled.
// Reset clears valid bits only; configuration registers reset to zero.

module ray_quad_intersect_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// ray transaction
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [rqi_pkg::CW-1:0]     origin_x,
	input  logic signed [rqi_pkg::CW-1:0]     origin_y,
	input  logic signed [rqi_pkg::CW-1:0]     origin_z,
	input  logic signed [rqi_pkg::CW-1:0]     dir_x,
	input  logic signed [rqi_pkg::CW-1:0]     dir_y,
	input  logic signed [rqi_pkg::CW-1:0]     dir_z,
	input  logic signed [rqi_pkg::CW-1:0]     t_min,
	input  logic signed [rqi_pkg::CW-1:0]     t_max,
	// result transaction
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic signed [rqi_pkg::CW-1:0]     hit_t,
	output logic signed [rqi_pkg::CW-1:0]     point_x,
	output logic signed [rqi_pkg::CW-1:0]     point_y,
	output logic signed [rqi_pkg::CW-1:0]     point_z,
	output logic [rqi_pkg::UV_W-1:0]          alpha,
	output logic [rqi_pkg::UV_W-1:0]          beta,
	output logic                              front_face,
	output logic [rqi_pkg::MAT_W-1:0]         hit_material,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [rqi_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [rqi_pkg::CFG_W-1:0]         cfg_data
);
	import rqi_pkg::*;

	// Configuration registers
	logic [VEC_W-1:0]     corner_q, edge_u_q, edge_v_q, normal_q, scale_q;
	logic signed [CW-1:0] offset_q;
	logic [MAT_W-1:0]     material_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q   <= '0;
			edge_u_q   <= '0;
			edge_v_q   <= '0;
			normal_q   <= '0;
			offset_q   <= '0;
			scale_q    <= '0;
			material_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CORNER:   corner_q   <= cfg_data;
				REG_EDGE_U:   edge_u_q   <= cfg_data;
				REG_EDGE_V:   edge_v_q   <= cfg_data;
				REG_NORMAL:   normal_q   <= cfg_data;
				REG_OFFSET:   offset_q   <= cfg_data[CW-1:0];
				REG_SCALE:    scale_q    <= cfg_data;
				REG_MATERIAL: material_q <= cfg_data[MAT_W-1:0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	// Global advance: everything moves unless the result register is held.
	logic en;
	assign en       = ~(out_valid & out_stall);
	assign in_stall = ~en;

	ray_t in_ray;
	always_comb begin
		in_ray.org   = {origin_z, origin_y, origin_x};
		in_ray.dir   = {dir_z, dir_y, dir_x};
		in_ray.t_min = t_min;
		in_ray.t_max = t_max;
	end

	// Stages 1-3: plane dots
	logic             pl_valid;
	ray_t             pl_ray;
	flags_t           pl_flags;
	logic [NUM_W-1:0] pl_num;
	logic [DEN_W-1:0] pl_den;

	rqi_plane u_plane (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_valid),
		.ray       (in_ray),
		.normal    (normal_q),
		.offset    (offset_q),
		.out_valid (pl_valid),
		.out_ray   (pl_ray),
		.out_flags (pl_flags),
		.num_mag   (pl_num),
		.den_mag   (pl_den)
	);

	// Stages 4-36: range check and quotient bits
	logic          dv_valid;
	ray_t          dv_ray;
	flags_t        dv_flags;
	logic [CW-1:0] dv_quot;

	rqi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pl_valid),
		.ray       (pl_ray),
		.flags     (pl_flags),
		.num_mag   (pl_num),
		.den_mag   (pl_den),
		.out_valid (dv_valid),
		.out_ray   (dv_ray),
		.out_flags (dv_flags),
		.quot      (dv_quot)
	);

	// Stages 37-45: point and planar coordinates
	logic                    sf_valid, sf_miss, sf_front;
	logic [CW-1:0]           sf_t;
	logic [2:0][CW-1:0]      sf_point;
	logic signed [ACC_W-1:0] sf_acc_a, sf_acc_b;

	rqi_surface u_surface (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_valid),
		.ray       (dv_ray),
		.flags     (dv_flags),
		.quot      (dv_quot),
		.corner    (corner_q),
		.edge_u    (edge_u_q),
		.edge_v    (edge_v_q),
		.scale     (scale_q),
		.out_valid (sf_valid),
		.miss      (sf_miss),
		.front     (sf_front),
		.t_val     (sf_t),
		.point     (sf_point),
		.acc_a     (sf_acc_a),
		.acc_b     (sf_acc_b)
	);

	// Stage 46: [0,1] tests on alpha/beta, miss zeroing, result register
	logic in_a, in_b, hit_c;
	assign in_a  = ~sf_acc_a[ACC_W-1] && (ACC_W'(sf_acc_a) < UV_BOUND);
	assign in_b  = ~sf_acc_b[ACC_W-1] && (ACC_W'(sf_acc_b) < UV_BOUND);
	assign hit_c = ~sf_miss & in_a & in_b;

	logic             res_valid_q, res_hit_q, res_front_q;
	logic [CW-1:0]    res_t_q, res_px_q, res_py_q, res_pz_q;
	logic [UV_W-1:0]  res_alpha_q, res_beta_q;
	logic [MAT_W-1:0] res_mat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (en) res_valid_q <= sf_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_hit_q   <= hit_c;
			res_t_q     <= hit_c ? sf_t : '0;
			res_px_q    <= hit_c ? sf_point[0] : '0;
			res_py_q    <= hit_c ? sf_point[1] : '0;
			res_pz_q    <= hit_c ? sf_point[2] : '0;
			res_alpha_q <= hit_c ? sf_acc_a[UV_SHIFT +: UV_W] : '0;
			res_beta_q  <= hit_c ? sf_acc_b[UV_SHIFT +: UV_W] : '0;
			res_front_q <= hit_c & sf_front;
			res_mat_q   <= hit_c ? material_q : '0;
		end
	end

	assign out_valid    = res_valid_q;
	assign hit          = res_hit_q;
	assign hit_t        = res_t_q;
	assign point_x      = res_px_q;
	assign point_y      = res_py_q;
	assign point_z      = res_pz_q;
	assign alpha        = res_alpha_q;
	assign beta         = res_beta_q;
	assign front_face   = res_front_q;
	assign hit_material = res_mat_q;

endmodule
